FILE: sv/h264rtp_pkg.sv
`timescale 1ns / 1ps

package h264rtp_pkg;

  localparam int unsigned MAX_NALS_PER_AU_DEF = 256;
  localparam int unsigned MAX_NAL_BYTES_DEF   = 65535;

  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 11;

  localparam logic [10:0] MAX_PAYLOAD_RST  = 11'd1200;
  localparam logic [6:0]  PAYLOAD_TYPE_RST = 7'd96;
  localparam logic [10:0] PAYLOAD_MIN      = 11'd1100;
  localparam logic [10:0] PAYLOAD_MAX      = 11'd1500;
  localparam logic [10:0] PEND_TOTAL_RST   = 11'd13;

  localparam logic [4:0] STAP_A_TYPE = 5'd24;
  localparam logic [4:0] FU_A_TYPE   = 5'd28;

  localparam logic [1:0] KIND_SINGLE = 2'd0;
  localparam logic [1:0] KIND_STAP   = 2'd1;
  localparam logic [1:0] KIND_FU     = 2'd2;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MAX_PAYLOAD  = 1'b0,
    REG_PAYLOAD_TYPE = 1'b1
  } cfg_reg_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_STAMP,
    S_DECIDE,
    S_FLUSH1,
    S_ACT,
    S_FU,
    S_FLUSH2
  } seq_state_e;

  typedef enum logic [1:0] {
    ACT_APPEND,
    ACT_GROUP,
    ACT_SINGLE,
    ACT_FRAG
  } nal_act_e;

  typedef enum logic [2:0] {
    TS_IDLE,
    TS_ABS,
    TS_MUL,
    TS_DIV,
    TS_SIGN
  } ts_state_e;

  typedef struct packed {
    logic        start;
    logic [62:0] t;
    logic [62:0] t0;
  } stamp_req_t;

  typedef struct packed {
    logic        done;
    logic [31:0] ts;
  } stamp_res_t;

  typedef struct packed {
    logic [1:0]  packet_kind;
    logic [7:0]  rtp_second_byte;
    logic [31:0] rtp_timestamp;
    logic [7:0]  payload_header;
    logic [7:0]  fu_header;
    logic [7:0]  first_nal;
    logic [8:0]  nal_count;
    logic [15:0] copy_offset;
    logic [10:0] copy_length;
    logic [10:0] packet_length;
    logic        last_of_run;
  } pkt_t;

endpackage

FILE: sv/h264rtp_nal_if.sv
`timescale 1ns / 1ps

interface h264rtp_nal_if;
  logic        valid;
  logic        ready;
  logic [15:0] nal_size;
  logic [7:0]  nal_header;
  logic [62:0] media_time_us;
  logic        last_nal;

  modport source (
    output valid, nal_size, nal_header, media_time_us, last_nal,
    input  ready
  );

  modport sink (
    input  valid, nal_size, nal_header, media_time_us, last_nal,
    output ready
  );
endinterface

FILE: sv/h264rtp_pkt_if.sv
`timescale 1ns / 1ps

interface h264rtp_pkt_if;
  logic        valid;
  logic        ready;
  logic [1:0]  packet_kind;
  logic [7:0]  rtp_second_byte;
  logic [31:0] rtp_timestamp;
  logic [7:0]  payload_header;
  logic [7:0]  fu_header;
  logic [7:0]  first_nal;
  logic [8:0]  nal_count;
  logic [15:0] copy_offset;
  logic [10:0] copy_length;
  logic [10:0] packet_length;
  logic        last_of_run;

  modport source (
    output valid, packet_kind, rtp_second_byte, rtp_timestamp, payload_header,
           fu_header, first_nal, nal_count, copy_offset, copy_length,
           packet_length, last_of_run,
    input  ready
  );

  modport sink (
    input  valid, packet_kind, rtp_second_byte, rtp_timestamp, payload_header,
           fu_header, first_nal, nal_count, copy_offset, copy_length,
           packet_length, last_of_run,
    output ready
  );
endinterface

FILE: sv/h264_rtp_packetizer.sv
`timescale 1ns / 1ps

// H.264 RTP packetizer (RFC 6184 packet planning). Takes one NAL unit
// descriptor per beat and returns RTP packet descriptors: NALs are packed
// greedily into a STAP-A while it fits max_payload, a group of one leaves as
// a single-NAL packet, and NALs too large for one packet are cut into FU-A
// fragments. The marker rides on the packet that closes the access unit; the
// timestamp is (time - first time) * 9 / 100 at 90 kHz. After its beat, a
// NAL waits while the timestamp is formed: difference, magnitude, times
// nine, a divide by 100 in three 24-bit digit steps on one reciprocal
// multiplier, sign, and hand-off to the planner. Then come a decide step, a
// flush of the pending group if it must close first, the act step, the FU-A
// fragments one after another, a flush of the group that ends the access
// unit, and the return to idle, where the next beat is taken. A step that
// emits a packet waits while the output register is full. Input is not ready
// while a NAL is in work. Finished packets wait in an output register, so the
// next NAL can be taken while the last packet is still pending. Write
// max_payload and payload_type only while the block is idle.
module h264_rtp_packetizer #(
  parameter int unsigned MAX_NALS_PER_AU = h264rtp_pkg::MAX_NALS_PER_AU_DEF,
  parameter int unsigned MAX_NAL_BYTES   = h264rtp_pkg::MAX_NAL_BYTES_DEF
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  cfg_we_i,
  input  logic [h264rtp_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [h264rtp_pkg::CFG_DATA_W-1:0]    cfg_wdata_i,
  h264rtp_nal_if.sink                           nal_i,
  h264rtp_pkt_if.source                         pkt_o
);
  import h264rtp_pkg::*;

  localparam int unsigned CAP_INT = (MAX_NALS_PER_AU < 511) ? MAX_NALS_PER_AU : 511;
  localparam logic [8:0]  CAP     = 9'(CAP_INT);
  localparam logic [15:0] NAL_LIM = 16'(MAX_NAL_BYTES);

  seq_state_e  state_q, state_d;
  nal_act_e    act_q, act_d;
  logic        flush2_q, flush2_d;
  logic [15:0] size_q, size_d;
  logic [7:0]  hdr_q, hdr_d;
  logic        last_q, last_d;
  logic [31:0] ts_q, ts_d;
  logic [15:0] off_q, off_d;

  logic [8:0]  pend_count_q, pend_count_d;
  logic [10:0] pend_total_q, pend_total_d;
  logic [7:0]  pend_first_q, pend_first_d;
  logic        pend_forb_q, pend_forb_d;
  logic [1:0]  pend_nri_q, pend_nri_d;
  logic [31:0] pend_ts_q, pend_ts_d;
  logic [7:0]  nal_index_q, nal_index_d;
  logic [62:0] start_time_q, start_time_d;
  logic        started_q, started_d;

  logic [10:0] max_payload_q;
  logic [6:0]  payload_type_q;

  logic        in_beat;
  stamp_req_t  stamp_req;
  stamp_res_t  stamp_res;

  logic [10:0] maxp;
  logic [16:0] sum_app;
  logic        fits_app, fits_group, fits_single;
  logic [15:0] frag_rem;
  logic [10:0] chunk;
  logic        frag_end;
  logic [10:0] frag_copy;

  logic        out_free;
  logic        push;
  pkt_t        pkt;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_payload_q  <= MAX_PAYLOAD_RST;
      payload_type_q <= PAYLOAD_TYPE_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_MAX_PAYLOAD:  max_payload_q  <= cfg_wdata_i;
        REG_PAYLOAD_TYPE: payload_type_q <= cfg_wdata_i[6:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      pend_count_q <= '0;
      pend_total_q <= PEND_TOTAL_RST;
      pend_first_q <= '0;
      pend_forb_q  <= 1'b0;
      pend_nri_q   <= '0;
      pend_ts_q    <= '0;
      nal_index_q  <= '0;
      start_time_q <= '0;
      started_q    <= 1'b0;
    end else begin
      state_q      <= state_d;
      pend_count_q <= pend_count_d;
      pend_total_q <= pend_total_d;
      pend_first_q <= pend_first_d;
      pend_forb_q  <= pend_forb_d;
      pend_nri_q   <= pend_nri_d;
      pend_ts_q    <= pend_ts_d;
      nal_index_q  <= nal_index_d;
      start_time_q <= start_time_d;
      started_q    <= started_d;
    end
  end

  always_ff @(posedge clk_i) begin
    act_q    <= act_d;
    flush2_q <= flush2_d;
    size_q   <= size_d;
    hdr_q    <= hdr_d;
    last_q   <= last_d;
    ts_q     <= ts_d;
    off_q    <= off_d;
  end

  assign in_beat     = nal_i.valid && nal_i.ready;
  assign nal_i.ready = (state_q == S_IDLE);

  assign stamp_req.start = in_beat;
  assign stamp_req.t     = nal_i.media_time_us;
  assign stamp_req.t0    = started_q ? start_time_q : nal_i.media_time_us;

  h264rtp_stamp u_stamp (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (stamp_req),
    .res_o  (stamp_res)
  );

  always_comb begin
    if (max_payload_q < PAYLOAD_MIN) begin
      maxp = PAYLOAD_MIN;
    end else if (max_payload_q > PAYLOAD_MAX) begin
      maxp = PAYLOAD_MAX;
    end else begin
      maxp = max_payload_q;
    end
  end

  assign sum_app     = 17'(pend_total_q) + 17'(size_q) + 17'd2;
  assign fits_app    = (pend_count_q != '0) && (pend_count_q < CAP) &&
                       (sum_app <= 17'(maxp));
  assign fits_group  = (17'(size_q) + 17'd15) <= 17'(maxp);
  assign fits_single = (17'(size_q) + 17'd12) <= 17'(maxp);

  assign frag_rem  = size_q - off_q;
  assign chunk     = maxp - 11'd14;
  assign frag_end  = frag_rem <= 16'(chunk);
  assign frag_copy = frag_end ? frag_rem[10:0] : chunk;

  // packet descriptor for the current step
  always_comb begin
    pkt = '0;
    pkt.rtp_second_byte[6:0] = payload_type_q;
    case (state_q)
      S_FLUSH1, S_FLUSH2: begin
        pkt.rtp_second_byte[7] = (state_q == S_FLUSH2);
        pkt.rtp_timestamp      = pend_ts_q;
        pkt.first_nal          = pend_first_q;
        if (pend_count_q == 9'd1) begin
          pkt.packet_kind   = KIND_SINGLE;
          pkt.nal_count     = 9'd1;
          pkt.copy_length   = pend_total_q - 11'd15;
          pkt.packet_length = pend_total_q - 11'd3;
        end else begin
          pkt.packet_kind    = KIND_STAP;
          pkt.payload_header = {pend_forb_q, pend_nri_q, STAP_A_TYPE};
          pkt.nal_count      = pend_count_q;
          pkt.packet_length  = pend_total_q;
        end
        if (state_q == S_FLUSH2) begin
          pkt.last_of_run = 1'b1;
        end else begin
          pkt.last_of_run = !(act_q == ACT_SINGLE || act_q == ACT_FRAG) && !flush2_q;
        end
      end
      S_ACT: begin
        pkt.packet_kind        = KIND_SINGLE;
        pkt.rtp_second_byte[7] = last_q;
        pkt.rtp_timestamp      = ts_q;
        pkt.first_nal          = nal_index_q;
        pkt.nal_count          = 9'd1;
        pkt.copy_length        = size_q[10:0];
        pkt.packet_length      = 11'(size_q + 16'd12);
        pkt.last_of_run        = 1'b1;
      end
      S_FU: begin
        pkt.packet_kind        = KIND_FU;
        pkt.rtp_second_byte[7] = frag_end && last_q;
        pkt.rtp_timestamp      = ts_q;
        pkt.payload_header     = {hdr_q[7:5], FU_A_TYPE};
        pkt.fu_header          = {off_q == 16'd1, (off_q != 16'd1) && frag_end, 1'b0,
                                  hdr_q[4:0]};
        pkt.first_nal          = nal_index_q;
        pkt.nal_count          = 9'd1;
        pkt.copy_offset        = off_q;
        pkt.copy_length        = frag_copy;
        pkt.packet_length      = frag_copy + 11'd14;
        pkt.last_of_run        = frag_end;
      end
      default: ;
    endcase
  end

  assign push = out_free &&
                (state_q == S_FLUSH1 || state_q == S_FLUSH2 || state_q == S_FU ||
                 (state_q == S_ACT && act_q == ACT_SINGLE));

  always_comb begin
    state_d      = state_q;
    act_d        = act_q;
    flush2_d     = flush2_q;
    size_d       = size_q;
    hdr_d        = hdr_q;
    last_d       = last_q;
    ts_d         = ts_q;
    off_d        = off_q;
    pend_count_d = pend_count_q;
    pend_total_d = pend_total_q;
    pend_first_d = pend_first_q;
    pend_forb_d  = pend_forb_q;
    pend_nri_d   = pend_nri_q;
    pend_ts_d    = pend_ts_q;
    nal_index_d  = nal_index_q;
    start_time_d = start_time_q;
    started_d    = started_q;
    case (state_q)
      S_IDLE: begin
        if (in_beat) begin
          size_d  = (nal_i.nal_size > NAL_LIM) ? NAL_LIM : nal_i.nal_size;
          hdr_d   = nal_i.nal_header;
          last_d  = nal_i.last_nal;
          state_d = S_STAMP;
          if (!started_q) begin
            start_time_d = nal_i.media_time_us;
            started_d    = 1'b1;
          end
        end
      end
      S_STAMP: begin
        if (stamp_res.done) begin
          ts_d    = stamp_res.ts;
          state_d = S_DECIDE;
        end
      end
      S_DECIDE: begin
        if (fits_app) begin
          act_d = ACT_APPEND;
        end else if (fits_group) begin
          act_d = ACT_GROUP;
        end else if (fits_single) begin
          act_d = ACT_SINGLE;
        end else begin
          act_d = ACT_FRAG;
        end
        flush2_d = last_q && (fits_app || fits_group);
        state_d  = (!fits_app && (pend_count_q != '0)) ? S_FLUSH1 : S_ACT;
      end
      S_FLUSH1: begin
        if (out_free) begin
          pend_count_d = '0;
          pend_total_d = PEND_TOTAL_RST;
          pend_forb_d  = 1'b0;
          pend_nri_d   = '0;
          state_d      = S_ACT;
        end
      end
      S_ACT: begin
        case (act_q)
          ACT_APPEND: begin
            pend_count_d = pend_count_q + 9'd1;
            pend_total_d = sum_app[10:0];
            pend_forb_d  = pend_forb_q | hdr_q[7];
            pend_nri_d   = (hdr_q[6:5] > pend_nri_q) ? hdr_q[6:5] : pend_nri_q;
            state_d      = flush2_q ? S_FLUSH2 : S_IDLE;
          end
          ACT_GROUP: begin
            pend_count_d = 9'd1;
            pend_total_d = 11'(size_q + 16'd15);
            pend_first_d = nal_index_q;
            pend_forb_d  = hdr_q[7];
            pend_nri_d   = hdr_q[6:5];
            pend_ts_d    = ts_q;
            state_d      = flush2_q ? S_FLUSH2 : S_IDLE;
          end
          ACT_SINGLE: begin
            if (out_free) begin
              state_d = S_IDLE;
            end
          end
          ACT_FRAG: begin
            off_d   = 16'd1;
            state_d = S_FU;
          end
          default: begin
            state_d = S_IDLE;
          end
        endcase
      end
      S_FU: begin
        if (out_free) begin
          off_d = off_q + 16'(frag_copy);
          if (frag_end) begin
            state_d = S_IDLE;
          end
        end
      end
      S_FLUSH2: begin
        if (out_free) begin
          pend_count_d = '0;
          pend_total_d = PEND_TOTAL_RST;
          pend_forb_d  = 1'b0;
          pend_nri_d   = '0;
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
    // advance the NAL index when the NAL is done, or clear it after the last NAL
    if (state_q != S_IDLE && state_d == S_IDLE) begin
      nal_index_d = last_q ? 8'd0 : nal_index_q + 8'd1;
    end
  end

  h264rtp_outreg u_outreg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .pkt_i  (pkt),
    .free_o (out_free),
    .pkt_o  (pkt_o)
  );

  a_pend_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_count_q == '0 |->
      pend_total_q == PEND_TOTAL_RST && !pend_forb_q && pend_nri_q == '0)
    else $error("empty group with stale totals");

  a_in_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_beat |=> !nal_i.ready)
    else $error("input taken while a NAL is in work");

  a_stamp_when: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stamp_res.done |-> state_q == S_STAMP)
    else $error("timestamp finished outside its wait state");

  a_pend_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_count_q <= CAP && pend_total_q <= PAYLOAD_MAX)
    else $error("pending group beyond its limits");

endmodule

FILE: sv/h264rtp_stamp.sv
`timescale 1ns / 1ps

module h264rtp_stamp (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  h264rtp_pkg::stamp_req_t req_i,
  output h264rtp_pkg::stamp_res_t res_o
);
  import h264rtp_pkg::*;

  localparam int unsigned DVD_W     = 72;
  localparam int unsigned DIG_W     = 24;
  localparam logic [1:0]  LAST_STEP = 2'd2;
  localparam logic [27:0] RECIP     = 28'hA3D70A4;
  localparam logic [6:0]  DIVISOR   = 7'd100;

  ts_state_e         state_q, state_d;
  logic [63:0]       diff_q, diff_d;
  logic              neg_q, neg_d;
  logic [DVD_W-1:0]  dvd_q, dvd_d;
  logic [6:0]        rem_q, rem_d;
  logic [31:0]       quo_q, quo_d;
  logic [1:0]        cnt_q, cnt_d;
  stamp_res_t        res_q, res_d;

  logic [30:0] part;
  logic [55:0] prod;
  logic [23:0] qdig;
  logic [30:0] back;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= TS_IDLE;
      res_q   <= '0;
    end else begin
      state_q <= state_d;
      res_q   <= res_d;
    end
  end

  always_ff @(posedge clk_i) begin
    diff_q <= diff_d;
    neg_q  <= neg_d;
    dvd_q  <= dvd_d;
    rem_q  <= rem_d;
    quo_q  <= quo_d;
    cnt_q  <= cnt_d;
  end

  // divide one 24-bit digit by 100: quarter it, then scale by 2^32 / 25
  assign part = {rem_q, dvd_q[DVD_W-1 -: DIG_W]};
  assign prod = 56'(part[30:2]) * 56'(RECIP);
  assign qdig = prod[55:32];
  assign back = 31'(qdig) * 31'(DIVISOR);

  always_comb begin
    state_d  = state_q;
    diff_d   = diff_q;
    neg_d    = neg_q;
    dvd_d    = dvd_q;
    rem_d    = rem_q;
    quo_d    = quo_q;
    cnt_d    = cnt_q;
    res_d    = res_q;
    res_d.done = 1'b0;
    case (state_q)
      TS_IDLE: begin
        if (req_i.start) begin
          diff_d  = {1'b0, req_i.t} - {1'b0, req_i.t0};
          state_d = TS_ABS;
        end
      end
      TS_ABS: begin
        neg_d   = diff_q[63];
        diff_d  = diff_q[63] ? (~diff_q + 64'd1) : diff_q;
        state_d = TS_MUL;
      end
      TS_MUL: begin
        dvd_d   = {5'b00000, diff_q, 3'b000} + {8'h00, diff_q};
        rem_d   = '0;
        quo_d   = '0;
        cnt_d   = '0;
        state_d = TS_DIV;
      end
      TS_DIV: begin
        rem_d = 7'(part - back);
        quo_d = {quo_q[7:0], qdig};
        dvd_d = {dvd_q[DVD_W-DIG_W-1:0], {DIG_W{1'b0}}};
        cnt_d = cnt_q + 2'd1;
        if (cnt_q == LAST_STEP) begin
          state_d = TS_SIGN;
        end
      end
      TS_SIGN: begin
        res_d.ts   = neg_q ? (32'd0 - quo_q) : quo_q;
        res_d.done = 1'b1;
        state_d    = TS_IDLE;
      end
      default: begin
        state_d = TS_IDLE;
      end
    endcase
  end

  assign res_o = res_q;

endmodule

FILE: sv/h264rtp_top_unused_guard.sv
`timescale 1ns / 1ps

module h264rtp_outreg (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  h264rtp_pkg::pkt_t pkt_i,
  output logic              free_o,
  h264rtp_pkt_if.source     pkt_o
);
  import h264rtp_pkg::*;

  logic valid_q, valid_d;
  pkt_t out_q, out_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign free_o = !valid_q || pkt_o.ready;

  always_comb begin
    valid_d = valid_q;
    out_d   = out_q;
    if (push_i && free_o) begin
      valid_d = 1'b1;
      out_d   = pkt_i;
    end else if (pkt_o.ready) begin
      valid_d = 1'b0;
    end
  end

  assign pkt_o.valid           = valid_q;
  assign pkt_o.packet_kind     = out_q.packet_kind;
  assign pkt_o.rtp_second_byte = out_q.rtp_second_byte;
  assign pkt_o.rtp_timestamp   = out_q.rtp_timestamp;
  assign pkt_o.payload_header  = out_q.payload_header;
  assign pkt_o.fu_header       = out_q.fu_header;
  assign pkt_o.first_nal       = out_q.first_nal;
  assign pkt_o.nal_count       = out_q.nal_count;
  assign pkt_o.copy_offset     = out_q.copy_offset;
  assign pkt_o.copy_length     = out_q.copy_length;
  assign pkt_o.packet_length   = out_q.packet_length;
  assign pkt_o.last_of_run     = out_q.last_of_run;

  a_fu_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q && out_q.packet_kind == KIND_FU |->
      out_q.packet_length == out_q.copy_length + 11'd14)
    else $error("FU-A length mismatch");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q && !pkt_o.ready |=> valid_q && $stable(out_q))
    else $error("output beat changed while stalled");

  a_single_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q && out_q.packet_kind != KIND_STAP |-> out_q.nal_count == 9'd1)
    else $error("single or FU-A packet with count other than one");

endmodule

FILE: tb/tb_h264_rtp_packetizer.sv
`timescale 1ns / 1ps

module tb_h264_rtp_packetizer;
  import h264rtp_pkg::*;

  typedef struct {
    logic [15:0] size;
    logic [7:0]  hdr;
    logic [62:0] t;
    logic        last;
  } nal_beat_t;

  class rtp_plan_board;
    pkt_t        plan_q[$];
    int unsigned errors;
    logic [10:0] max_payload;
    logic [6:0]  payload_type;
    logic [8:0]  grp_count;
    logic [10:0] grp_total;
    logic [7:0]  grp_first;
    logic        grp_f;
    logic [1:0]  grp_nri;
    logic [31:0] grp_stamp;
    logic [7:0]  au_index;
    logic [62:0] t_origin;
    logic        t_locked;

    function new();
      errors       = 0;
      max_payload  = MAX_PAYLOAD_RST;
      payload_type = PAYLOAD_TYPE_RST;
      grp_count    = '0;
      grp_total    = PEND_TOTAL_RST;
      grp_first    = '0;
      grp_f        = 1'b0;
      grp_nri      = '0;
      grp_stamp    = '0;
      au_index     = '0;
      t_origin     = '0;
      t_locked     = 1'b0;
    endfunction

    function void set_reg(cfg_reg_e r, logic [10:0] v);
      case (r)
        REG_MAX_PAYLOAD:  max_payload = v;
        REG_PAYLOAD_TYPE: payload_type = v[6:0];
        default: ;
      endcase
    endfunction

    function logic [31:0] stamp_90k(logic [62:0] t);
      logic        behind;
      logic [63:0] span;
      logic [63:0] q;
      logic [31:0] r;
      behind = t < t_origin;
      span   = behind ? {1'b0, t_origin} - {1'b0, t} : {1'b0, t} - {1'b0, t_origin};
      q      = (span / 64'd100) * 64'd9 + ((span % 64'd100) * 64'd9) / 64'd100;
      r      = q[31:0];
      return behind ? 32'd0 - r : r;
    endfunction

    function void emit(logic [1:0] kind, logic mark, logic [31:0] ts, logic [7:0] ph,
                       logic [7:0] fh, logic [7:0] first, logic [8:0] cnt,
                       logic [15:0] off, logic [10:0] len, logic [10:0] plen);
      pkt_t p;
      p.packet_kind     = kind;
      p.rtp_second_byte = {mark, payload_type};
      p.rtp_timestamp   = ts;
      p.payload_header  = ph;
      p.fu_header       = fh;
      p.first_nal       = first;
      p.nal_count       = cnt;
      p.copy_offset     = off;
      p.copy_length     = len;
      p.packet_length   = plen;
      p.last_of_run     = 1'b0;
      plan_q.insert(plan_q.size(), p);
    endfunction

    function void close_group(logic mark);
      if (grp_count == 9'd1) begin
        emit(KIND_SINGLE, mark, grp_stamp, 8'd0, 8'd0, grp_first, 9'd1, 16'd0,
             grp_total - 11'd15, grp_total - 11'd3);
      end else begin
        emit(KIND_STAP, mark, grp_stamp, {grp_f, grp_nri, STAP_A_TYPE}, 8'd0, grp_first,
             grp_count, 16'd0, 11'd0, grp_total);
      end
      grp_count = '0;
      grp_total = PEND_TOTAL_RST;
      grp_f     = 1'b0;
      grp_nri   = '0;
    endfunction

    function void note_nal(nal_beat_t b);
      int unsigned sz;
      int unsigned lim;
      int unsigned chunk;
      int unsigned off;
      int unsigned copy;
      int unsigned base;
      logic        fin;
      logic [7:0]  fh;
      logic [31:0] ts;
      sz  = b.size;
      if (sz > MAX_NAL_BYTES_DEF) sz = MAX_NAL_BYTES_DEF;
      lim = max_payload;
      if (lim < PAYLOAD_MIN) lim = PAYLOAD_MIN;
      if (lim > PAYLOAD_MAX) lim = PAYLOAD_MAX;
      base = plan_q.size();
      if (!t_locked) begin
        t_origin = b.t;
        t_locked = 1'b1;
      end
      ts = stamp_90k(b.t);
      if (grp_count > 0 && grp_count < MAX_NALS_PER_AU_DEF && grp_total + 2 + sz <= lim) begin
        grp_count++;
        grp_total = grp_total + 11'(2 + sz);
        grp_f     = grp_f | b.hdr[7];
        if (b.hdr[6:5] > grp_nri) grp_nri = b.hdr[6:5];
      end else begin
        if (grp_count > 0) close_group(1'b0);
        if (15 + sz <= lim) begin
          grp_count = 9'd1;
          grp_total = 11'(15 + sz);
          grp_first = au_index;
          grp_f     = b.hdr[7];
          grp_nri   = b.hdr[6:5];
          grp_stamp = ts;
        end else if (12 + sz <= lim) begin
          emit(KIND_SINGLE, b.last, ts, 8'd0, 8'd0, au_index, 9'd1, 16'd0, 11'(sz),
               11'(12 + sz));
        end else begin
          chunk = lim - 14;
          off   = 1;
          while (off < sz) begin
            copy = (sz - off < chunk) ? sz - off : chunk;
            fin  = (off + copy == sz);
            fh   = {3'b000, b.hdr[4:0]};
            if (off == 1) fh[7] = 1'b1;
            else if (fin) fh[6] = 1'b1;
            emit(KIND_FU, fin ? b.last : 1'b0, ts, {b.hdr[7:5], FU_A_TYPE}, fh, au_index,
                 9'd1, 16'(off), 11'(copy), 11'(14 + copy));
            off += copy;
          end
        end
      end
      if (b.last && grp_count > 0) close_group(1'b1);
      au_index = b.last ? 8'd0 : au_index + 8'd1;
      if (plan_q.size() > base) plan_q[plan_q.size() - 1].last_of_run = 1'b1;
    endfunction

    task report(string msg);
      if (errors < 40) $display("mismatch @%0t: %s", $realtime, msg);
      errors++;
    endtask

    task cmp(string name, logic [31:0] got, logic [31:0] want, logic [7:0] first);
      if (got !== want)
        report($sformatf("%s got 0x%0h want 0x%0h (first_nal %0d)", name, got, want, first));
    endtask

    task check_pkt(pkt_t got);
      pkt_t want;
      if (plan_q.size() == 0) begin
        report($sformatf("unexpected packet %p", got));
        return;
      end
      want = plan_q.pop_front();
      cmp("packet_kind", got.packet_kind, want.packet_kind, want.first_nal);
      cmp("rtp_second_byte", got.rtp_second_byte, want.rtp_second_byte, want.first_nal);
      cmp("rtp_timestamp", got.rtp_timestamp, want.rtp_timestamp, want.first_nal);
      cmp("payload_header", got.payload_header, want.payload_header, want.first_nal);
      cmp("fu_header", got.fu_header, want.fu_header, want.first_nal);
      cmp("first_nal", got.first_nal, want.first_nal, want.first_nal);
      cmp("nal_count", got.nal_count, want.nal_count, want.first_nal);
      cmp("copy_offset", got.copy_offset, want.copy_offset, want.first_nal);
      cmp("copy_length", got.copy_length, want.copy_length, want.first_nal);
      cmp("packet_length", got.packet_length, want.packet_length, want.first_nal);
      cmp("last_of_run", got.last_of_run, want.last_of_run, want.first_nal);
    endtask
  endclass

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_wdata_i;

  h264rtp_nal_if nal_bus ();
  h264rtp_pkt_if pkt_bus ();

  h264_rtp_packetizer u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .nal_i       (nal_bus),
    .pkt_o       (pkt_bus)
  );

  rtp_plan_board board = new();
  nal_beat_t     stim_q[$];
  logic [62:0]   au_time = 63'h2000_0000_0001_0000;
  int unsigned   burst_left = 0;
  logic          hold_req = 1'b0;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #20_000_000;
    $display("status: fail");
    $finish;
  end

  function automatic void push_nal(logic [15:0] size, logic [7:0] hdr, logic [62:0] t,
                                   logic last);
    nal_beat_t b;
    b.size = size;
    b.hdr  = hdr;
    b.t    = t;
    b.last = last;
    stim_q.insert(stim_q.size(), b);
  endfunction

  function automatic logic [15:0] pick_size();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 16'($urandom_range(0, 400));
    if (r < 75) return 16'($urandom_range(400, 1100));
    if (r < 92) return 16'($urandom_range(1080, 1520));
    if (r < 97) return 16'($urandom_range(1520, 6000));
    return 16'($urandom);
  endfunction

  task automatic add_random(int unsigned n);
    int unsigned made;
    int unsigned nals;
    logic [63:0] r64;
    made = 0;
    while (made < n) begin
      if ($urandom_range(0, 99) < 85) begin
        au_time = au_time + 63'($urandom_range(1000, 50000));
        nals    = $urandom_range(1, 8);
        for (int unsigned k = 0; k < nals; k++)
          push_nal(pick_size(), 8'($urandom), au_time, k == nals - 1);
        made += nals;
      end else begin
        r64 = {$urandom, $urandom};
        push_nal(16'($urandom), 8'($urandom), r64[62:0], 1'($urandom_range(0, 1)));
        made++;
      end
    end
  endtask

  task automatic send_all();
    nal_beat_t   b;
    int unsigned gap;
    foreach (stim_q[k]) begin
      b   = stim_q[k];
      gap = 0;
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 10);
        if ($urandom_range(0, 3) != 0) gap = $urandom_range(1, 90);
      end
      burst_left--;
      if (gap != 0) begin
        nal_bus.valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      nal_bus.valid         <= 1'b1;
      nal_bus.nal_size      <= b.size;
      nal_bus.nal_header    <= b.hdr;
      nal_bus.media_time_us <= b.t;
      nal_bus.last_nal      <= b.last;
      do @(posedge clk_i); while (!nal_bus.ready);
      board.note_nal(b);
    end
    nal_bus.valid <= 1'b0;
    stim_q.delete();
  endtask

  task automatic drain();
    while (board.plan_q.size() != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
  endtask

  task automatic program_regs(logic [10:0] mp, logic [6:0] pt);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= REG_MAX_PAYLOAD;
    cfg_wdata_i <= mp;
    @(posedge clk_i);
    board.set_reg(REG_MAX_PAYLOAD, mp);
    cfg_idx_i   <= REG_PAYLOAD_TYPE;
    cfg_wdata_i <= {4'd0, pt};
    @(posedge clk_i);
    board.set_reg(REG_PAYLOAD_TYPE, {4'd0, pt});
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  function automatic pkt_t take_pkt();
    pkt_t p;
    p.packet_kind     = pkt_bus.packet_kind;
    p.rtp_second_byte = pkt_bus.rtp_second_byte;
    p.rtp_timestamp   = pkt_bus.rtp_timestamp;
    p.payload_header  = pkt_bus.payload_header;
    p.fu_header       = pkt_bus.fu_header;
    p.first_nal       = pkt_bus.first_nal;
    p.nal_count       = pkt_bus.nal_count;
    p.copy_offset     = pkt_bus.copy_offset;
    p.copy_length     = pkt_bus.copy_length;
    p.packet_length   = pkt_bus.packet_length;
    p.last_of_run     = pkt_bus.last_of_run;
    return p;
  endfunction

  initial begin : rx
    int unsigned mode;
    int unsigned mode_left;
    mode      = 0;
    mode_left = 0;
    pkt_bus.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (pkt_bus.valid && pkt_bus.ready) board.check_pkt(take_pkt());
      if (hold_req) begin
        // hold off long enough for the block to back up into its input
        hold_req = 1'b0;
        pkt_bus.ready <= 1'b0;
        repeat (400) @(posedge clk_i);
      end
      if (mode_left == 0) begin
        mode      = $urandom_range(0, 3);
        mode_left = $urandom_range(10, 80);
      end
      mode_left--;
      case (mode)
        0: pkt_bus.ready <= 1'b1;
        1: pkt_bus.ready <= $urandom_range(0, 3) != 0;
        2: pkt_bus.ready <= $urandom_range(0, 3) == 0;
        default: pkt_bus.ready <= ~pkt_bus.ready;
      endcase
    end
  end

  initial begin : main
    logic [10:0] mp_list [7];
    logic [6:0]  pt_list [7];
    mp_list = '{11'd0, 11'd2047, 11'd1100, 11'd1500, 11'd1099, 11'd1501, 11'd1200};
    pt_list = '{7'd127, 7'd0, 7'd35, 7'd127, 7'd96, 7'd1, 7'd0};
    mp_list[6] = 11'($urandom_range(1100, 1500));
    pt_list[6] = 7'($urandom_range(0, 127));

    rst_ni                <= 1'b0;
    cfg_we_i              <= 1'b0;
    cfg_idx_i             <= '0;
    cfg_wdata_i           <= '0;
    nal_bus.valid         <= 1'b0;
    nal_bus.nal_size      <= '0;
    nal_bus.nal_header    <= '0;
    nal_bus.media_time_us <= '0;
    nal_bus.last_nal      <= 1'b0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset limits: aggregation, marker flush, split runs, time behind origin
    push_nal(16'd100,   8'h67, 63'h2000_0000_0000_0000, 1'b0);
    push_nal(16'd50,    8'hE8, 63'h2000_0000_0000_0000, 1'b0);
    push_nal(16'd0,     8'h06, 63'h2000_0000_0000_0000, 1'b1);
    push_nal(16'd1,     8'h65, 63'd1000,                1'b1);
    push_nal(16'd1186,  8'h41, 63'h2000_0000_0000_1000, 1'b1);
    push_nal(16'd1185,  8'h21, 63'h2000_0000_0000_2000, 1'b0);
    push_nal(16'd1,     8'h01, 63'h2000_0000_0000_2000, 1'b1);
    push_nal(16'd65535, 8'hFF, 63'h7FFF_FFFF_FFFF_FFFF, 1'b1);
    push_nal(16'd1189,  8'h25, 63'h2000_0000_0000_3000, 1'b0);
    push_nal(16'd1188,  8'h45, 63'h2000_0000_0000_3000, 1'b0);
    push_nal(16'd1187,  8'h05, 63'h2000_0000_0000_3000, 1'b1);
    push_nal(16'd2,     8'h00, 63'd0,                   1'b0);
    push_nal(16'd3,     8'h80, 63'd0,                   1'b0);
    push_nal(16'd2000,  8'h7C, 63'd0,                   1'b1);
    push_nal(16'd600,   8'h5A, 63'h2000_0000_0000_4000, 1'b0);
    push_nal(16'd570,   8'hBA, 63'h2000_0000_0000_4000, 1'b0);
    push_nal(16'd700,   8'h3B, 63'h2000_0000_0000_4000, 1'b1);
    send_all();
    drain();

    for (int ph = 0; ph < 7; ph++) begin
      program_regs(mp_list[ph], pt_list[ph]);
      add_random(26);
      if (ph == 1) hold_req = 1'b1;
      send_all();
      drain();
    end

    if (board.errors == 0 && board.plan_q.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
